// ===== design/brba_pkg.sv =====
`timescale 1ns / 1ps

package brba_pkg;

    localparam int unsigned MS_W       = 16;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned INTERVAL_W = 24;
    localparam int unsigned SUM_W      = 24;
    localparam int unsigned DIV_W      = 24;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned AVG_COUNT_DEF = 8;

    // 60000 * 256, rate numerator for 8.8 bpm
    localparam logic [DIV_W-1:0]      RATE_NUMER   = 24'd15360000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 24'hFFFFFF;

    localparam logic [RATE_W-1:0] RATE_MIN_RST   = 16'd10240;
    localparam logic [RATE_W-1:0] RATE_MAX_RST   = 16'd51200;
    localparam logic [RATE_W-1:0] RATE_OFFSET_RST = 16'd0;
    localparam logic [RATE_W-1:0] JUMP_LIMIT_RST = 16'd12800;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_MIN    = 8'd0,
        REG_RATE_MAX    = 8'd1,
        REG_RATE_OFFSET = 8'd2,
        REG_JUMP_LIMIT  = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [MS_W-1:0] elapsed_ms;
        logic            beat_seen;
    } in_beat_t;

    typedef struct packed {
        logic [RATE_W-1:0] mean_rate;
        logic              mean_updated;
        logic              value_accepted;
    } out_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/brba_div.sv =====
`timescale 1ns / 1ps

module brba_div #(
    parameter int unsigned W = brba_pkg::DIV_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output logic [W-1:0]        quotient,
    output brba_pkg::div_stat_t stat
);
    import brba_pkg::*;

    localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     divisor_reg, divisor_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(W - 1);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/beat_rate_block_averager_top.sv =====
`timescale 1ns / 1ps

// channel   ports                               direction  carries
// s_        s_valid s_ready s_data              in         elapsed_ms, beat_seen
// m_        m_valid m_ready m_data              out        mean_rate, mean_updated,
//                                                          value_accepted
// cfg_      cfg_valid cfg_ready cfg_index cfg_data  in     register writes
//
// a beat without a heartbeat, or with a zero interval, passes from ST_START straight to ST_OUT
// a heartbeat runs the single 24-bit restoring divider, one quotient bit a cycle, for its rate;
// a rejected rate then goes to ST_OUT, a stored one passes ST_VALUE and ST_JUMP, and a published mean reruns it
// s_ready is high only while idle; the result sits in an output register, so
// the next beat is taken while m_ready is held low
// aresetn is synchronous, active low; cfg_ready is always high

module beat_rate_block_averager_top #(
    parameter int unsigned AVG_COUNT = brba_pkg::AVG_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  brba_pkg::in_beat_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output brba_pkg::out_beat_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import brba_pkg::*;

    localparam int unsigned CNT_W = $clog2(AVG_COUNT + 1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_START    = 8'b0000_0010,
        ST_RATE_DIV = 8'b0000_0100,
        ST_RANGE    = 8'b0000_1000,
        ST_MEAN_DIV = 8'b0001_0000,
        ST_VALUE    = 8'b0010_0000,
        ST_JUMP     = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]     rate_min_reg, rate_max_reg, rate_offset_reg, jump_limit_reg;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                  beat_reg, beat_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [RATE_W-1:0]     mean_reg, mean_next;
    logic [DIV_W-1:0]      rate_reg, rate_next;
    logic [RATE_W-1:0]     val_reg, val_next;
    logic                  upd_reg, upd_next;
    logic                  acc_reg, acc_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend, div_divisor, div_quotient;
    div_stat_t        div_stat;

    logic [INTERVAL_W:0]  interval_sum;
    logic [DIV_W-1:0]     mean_clamp;
    logic signed [17:0]   val_raw, val_clamp;
    logic [RATE_W:0]      jump_diff, jump_abs;

    brba_div #(
        .W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_min_reg    <= RATE_MIN_RST;
            rate_max_reg    <= RATE_MAX_RST;
            rate_offset_reg <= RATE_OFFSET_RST;
            jump_limit_reg  <= JUMP_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RATE_MIN:    rate_min_reg    <= cfg_data;
                REG_RATE_MAX:    rate_max_reg    <= cfg_data;
                REG_RATE_OFFSET: rate_offset_reg <= cfg_data;
                REG_JUMP_LIMIT:  jump_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath pieces, each used in its own state
    always_comb begin
        interval_sum = {1'b0, interval_reg} + (INTERVAL_W + 1)'(s_data.elapsed_ms);

        mean_clamp = div_quotient;
        if (mean_clamp < DIV_W'(rate_min_reg)) mean_clamp = DIV_W'(rate_min_reg);
        if (mean_clamp > DIV_W'(rate_max_reg)) mean_clamp = DIV_W'(rate_max_reg);

        // rate is below rate_max here, so its low 16 bits are exact
        val_raw   = $signed({2'b00, rate_reg[RATE_W-1:0]})
                  + $signed({{2{rate_offset_reg[RATE_W-1]}}, rate_offset_reg});
        val_clamp = val_raw;
        if (val_clamp < $signed({2'b00, rate_min_reg})) val_clamp = $signed({2'b00, rate_min_reg});
        if (val_clamp > $signed({2'b00, rate_max_reg})) val_clamp = $signed({2'b00, rate_max_reg});

        jump_diff = {1'b0, mean_reg} - {1'b0, val_reg};
        jump_abs  = jump_diff[RATE_W] ? (~jump_diff + 1'b1) : jump_diff;
    end

    always_comb begin
        state_next    = state_reg;
        interval_next = interval_reg;
        beat_next     = beat_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        mean_next     = mean_reg;
        rate_next     = rate_reg;
        val_next      = val_reg;
        upd_next      = upd_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        div_dividend  = RATE_NUMER;
        div_divisor   = interval_reg;
        s_ready       = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    interval_next = interval_sum[INTERVAL_W] ? INTERVAL_MAX
                                                             : interval_sum[INTERVAL_W-1:0];
                    beat_next     = s_data.beat_seen;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                upd_next = 1'b0;
                acc_next = 1'b0;
                if (beat_reg) begin
                    interval_next = '0;
                    if (interval_reg != '0) begin
                        div_start  = 1'b1;
                        state_next = ST_RATE_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RATE_DIV: begin
                if (div_stat.done) begin
                    rate_next  = div_quotient;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                if (rate_reg > DIV_W'(rate_min_reg) && rate_reg < DIV_W'(rate_max_reg)) begin
                    acc_next = 1'b1;
                    if (count_reg >= CNT_W'(AVG_COUNT)) begin
                        div_start    = 1'b1;
                        div_dividend = sum_reg;
                        div_divisor  = DIV_W'(AVG_COUNT);
                        state_next   = ST_MEAN_DIV;
                    end else begin
                        state_next = ST_VALUE;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MEAN_DIV: begin
                if (div_stat.done) begin
                    mean_next  = mean_clamp[RATE_W-1:0];
                    upd_next   = 1'b1;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_VALUE;
                end
            end
            ST_VALUE: begin
                val_next   = val_clamp[RATE_W-1:0];
                state_next = ST_JUMP;
            end
            ST_JUMP: begin
                // a zero mean means none published yet
                if (mean_reg != '0 && jump_abs > {1'b0, jump_limit_reg}) begin
                    sum_next = sum_reg + SUM_W'(mean_reg);
                end else begin
                    sum_next = sum_reg + SUM_W'(val_reg);
                end
                count_next = count_reg + 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.mean_rate      = mean_reg;
                    m_data_next.mean_updated   = upd_reg;
                    m_data_next.value_accepted = acc_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            interval_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            mean_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            interval_reg <= interval_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            mean_reg     <= mean_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg   <= beat_next;
        rate_reg   <= rate_next;
        val_reg    <= val_next;
        upd_reg    <= upd_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(AVG_COUNT))
        else $error("value count beyond block size");

    a_publish_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.mean_updated) |-> m_data_reg.value_accepted)
        else $error("mean published without an accepted value");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_RATE_DIV || state_reg == ST_MEAN_DIV))
        else $error("divider finished with no state waiting on it");

endmodule

// ===== test/beat_rate_block_averager_top_tb.sv =====
`timescale 1ns / 1ps

module beat_rate_block_averager_top_tb;
    import brba_pkg::*;

    localparam int unsigned AVG_N      = 8;
    localparam int unsigned BPM_NUMER  = 60000 * 256;
    localparam int unsigned CYCLE_CAP  = 1000000;
    localparam int unsigned SETTLE_CYC = 80;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and state
    logic [15:0]        cf_min = RATE_MIN_RST;
    logic [15:0]        cf_max = RATE_MAX_RST;
    logic signed [15:0] cf_offset = RATE_OFFSET_RST;
    logic [15:0]        cf_jump = JUMP_LIMIT_RST;
    logic [23:0]        iv_ms = '0;
    logic [23:0]        run_sum = '0;
    logic [4:0]         run_count = '0;
    logic [15:0]        pub_mean = '0;

    in_beat_t  beat_q[$];
    out_beat_t rate_expect_q[$];
    out_beat_t exp_head;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_stored = 0;
    int unsigned n_published = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned hold_gap = 0;
    bit          s_taken = 1'b0;
    bit          calm = 1'b0;

    beat_rate_block_averager_top #(
        .AVG_COUNT(AVG_N)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_bpm(int v);
        if (v < int'(cf_min)) v = int'(cf_min);
        if (v > int'(cf_max)) v = int'(cf_max);
        return v;
    endfunction

    function automatic out_beat_t predict_rate(in_beat_t b);
        logic [24:0] widened;
        int unsigned rate;
        int          val;
        int          diff;
        out_beat_t   r;
        r.mean_updated   = 1'b0;
        r.value_accepted = 1'b0;
        widened = {1'b0, iv_ms} + 25'(b.elapsed_ms);
        iv_ms = widened[24] ? 24'hFFFFFF : widened[23:0];
        if (b.beat_seen) begin
            // zero interval means an infinite rate, never stored
            if (iv_ms != 0) begin
                rate = BPM_NUMER / iv_ms;
                if (rate > cf_min && rate < cf_max) begin
                    r.value_accepted = 1'b1;
                    if (run_count >= AVG_N) begin
                        pub_mean = 16'(clamp_bpm(int'(run_sum / AVG_N)));
                        r.mean_updated = 1'b1;
                        run_sum = '0;
                        run_count = '0;
                    end
                    val = clamp_bpm(int'(rate) + int'(cf_offset));
                    // a zero mean means none published yet
                    if (pub_mean != 0) begin
                        diff = int'(pub_mean) - val;
                        if (diff < 0) diff = -diff;
                        if (diff > int'(cf_jump)) val = int'(pub_mean);
                    end
                    run_sum = run_sum + 24'(val[15:0]);
                    run_count = run_count + 5'd1;
                end
            end
            iv_ms = '0;
        end
        r.mean_rate = pub_mean;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
    endtask

    // monitor and predictor
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        s_taken <= s_valid && s_ready && aresetn;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_cfg_writes++;
                case (cfg_reg_t'(cfg_index))
                    REG_RATE_MIN:    cf_min = cfg_data;
                    REG_RATE_MAX:    cf_max = cfg_data;
                    REG_RATE_OFFSET: cf_offset = cfg_data;
                    REG_JUMP_LIMIT:  cf_jump = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (rate_expect_q.size() == 0) begin
                    flag_mismatch("beat result with nothing pending", 0, 0);
                end else begin
                    exp_head = rate_expect_q.pop_front();
                    if (m_data.mean_rate !== exp_head.mean_rate)
                        flag_mismatch("mean_rate", m_data.mean_rate, exp_head.mean_rate);
                    if (m_data.mean_updated !== exp_head.mean_updated)
                        flag_mismatch("mean_updated", m_data.mean_updated,
                                      exp_head.mean_updated);
                    if (m_data.value_accepted !== exp_head.value_accepted)
                        flag_mismatch("value_accepted", m_data.value_accepted,
                                      exp_head.value_accepted);
                end
                n_results++;
            end
            if (s_valid && s_ready) begin
                n_accepted++;
                exp_head = predict_rate(s_data);
                if (exp_head.value_accepted) n_stored++;
                if (exp_head.mean_updated) n_published++;
                rate_expect_q.push_back(exp_head);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, rate_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_taken) begin
                // beat still waiting for ready
            end else if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end else if (beat_q.size() > 0) begin
                s_data <= beat_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (hold_gap > 0) begin
            m_ready <= 1'b0;
            hold_gap <= hold_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            hold_gap <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_item(logic [15:0] elapsed, logic beat);
        in_beat_t b;
        b.elapsed_ms = elapsed;
        b.beat_seen = beat;
        beat_q.push_back(b);
        n_queued++;
    endtask

    // one heartbeat interval spread over one to three beats
    task automatic queue_heartbeat(int unsigned span);
        int unsigned pieces;
        int unsigned rem;
        int unsigned part;
        pieces = $urandom_range(1, 3);
        rem = span;
        for (int i = 1; i < pieces; i++) begin
            part = $urandom_range(0, rem);
            queue_item(16'(part), 1'b0);
            rem -= part;
        end
        queue_item(16'(rem), 1'b1);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (n_accepted != n_queued || rate_expect_q.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] offs,
                            logic [15:0] jump);
        write_reg(REG_RATE_MIN, lo);
        write_reg(REG_RATE_MAX, hi);
        write_reg(REG_RATE_OFFSET, offs);
        write_reg(REG_JUMP_LIMIT, jump);
    endtask

    task automatic run_phase(int unsigned n_items, int unsigned span_lo, int unsigned span_hi);
        int unsigned start;
        int unsigned base;
        int unsigned pick;
        int unsigned span;
        start = n_queued;
        base = $urandom_range(span_lo, span_hi);
        while (n_queued - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 9) == 0) base = $urandom_range(span_lo, span_hi);
                // mostly a steady rhythm, sometimes an artifact far from it
                if ($urandom_range(0, 6) == 0)
                    span = $urandom_range(span_lo, span_hi);
                else
                    span = base + $urandom_range(0, 80) - 40;
                queue_heartbeat(span);
            end else if (pick < 90) begin
                queue_item(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                queue_item(16'd0, 1'b1);
            end else begin
                queue_item(16'($urandom_range(1, 299)), 1'b1);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats with the reset register values
        queue_item(16'd0, 1'b1);
        queue_item(16'hFFFF, 1'b0);
        queue_item(16'hFFFF, 1'b1);
        queue_item(16'd1, 1'b1);
        queue_item(16'd300, 1'b1);
        queue_item(16'd1500, 1'b1);
        queue_item(16'd301, 1'b1);
        queue_item(16'd1499, 1'b1);
        for (int i = 0; i < 6; i++) queue_item(16'd800, 1'b1);
        queue_item(16'd600, 1'b1);
        queue_item(16'd301, 1'b1);
        queue_item(16'd0, 1'b0);
        queue_item(16'd1000, 1'b1);
        queue_item(16'd0, 1'b1);
        wait_idle();

        // widest range, no jump tolerance
        set_regs(16'd0, 16'hFFFF, 16'd0, 16'd0);
        run_phase(220, 200, 3000);

        set_regs(RATE_MIN_RST, RATE_MAX_RST, 16'h0500, 16'hFFFF);
        // interval counter runs into saturation
        for (int i = 0; i < 257; i++) queue_item(16'hFFFF, 1'b0);
        queue_item(16'h1234, 1'b1);
        run_phase(220, 280, 1600);

        set_regs(RATE_MIN_RST, RATE_MAX_RST, 16'h8000, JUMP_LIMIT_RST);
        run_phase(200, 280, 1600);

        set_regs(RATE_MIN_RST, RATE_MAX_RST, 16'h7FFF, 16'd0);
        run_phase(200, 280, 1600);

        // inverted bounds, nothing can be stored
        set_regs(16'hFFFF, 16'd0, 16'd0, JUMP_LIMIT_RST);
        run_phase(60, 200, 3000);

        for (int p = 0; p < 3; p++) begin
            set_regs(16'($urandom_range(5000, 20000)), 16'($urandom_range(30000, 60000)),
                     16'($urandom_range(0, 2560) - 1280), 16'($urandom_range(0, 20000)));
            run_phase(150, 250, 3100);
        end

        set_regs(RATE_MIN_RST, RATE_MAX_RST, RATE_OFFSET_RST, JUMP_LIMIT_RST);
        calm = 1'b1;
        run_phase(150, 280, 1600);

        repeat (SETTLE_CYC) @(negedge aclk);
        $display("run covered %0d beats over %0d register writes", n_accepted, n_cfg_writes);
        $display("%0d rates stored, %0d means published, %0d results checked",
                 n_stored, n_published, n_results);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/brba_pkg.sv
design/brba_div.sv
design/beat_rate_block_averager_top.sv
test/beat_rate_block_averager_top_tb.sv
